>>> design/bfd_pkg.sv
package bfd_pkg;

   // default line store depth in pixels
   localparam int MAX_WIDTH_DEF = 2048;

   // field and datapath widths
   localparam int PIX_W  = 8;
   localparam int NCH    = 4;
   localparam int SUM_W  = 32;
   localparam int AREA_W = 28;
   localparam int SW_W   = 12;
   localparam int SH_W   = 16;
   localparam int BND_NW = 32;
   localparam int BND_DW = 16;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 16;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
   localparam logic [IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
   localparam logic [IDX_W-1:0] REG_DST_WIDTH     = 3'd2;
   localparam logic [IDX_W-1:0] REG_DST_HEIGHT    = 3'd3;
   localparam logic [IDX_W-1:0] REG_FOUR_CHANNELS = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_INIT_COL,
      ST_INIT_ROW,
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_PUSH
   } state_type;

   // per-lane line store and divider control
   typedef struct packed {
      logic wr_en;
      logic wr_zero;
      logic div_start;
   } lane_ctl_type;

endpackage

>>> design/box_filter_downscaler_top.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_in_ch0..3
// rsp_      out        rsp_valid/rsp_stall  rsp_out_ch0..3, rsp_row_last, rsp_frame_last
// csr_      in         csr_we               csr_index, csr_wdata
//
// each pixel passes the idle, read and divide states; one that moves a box edge waits in
// the divide state for the 32-step box bound divider, one that emits waits there for the
// 32-step lane dividers (lane averages), then in the push state for the output register
// reset and every csr write start a clearing pass over all MAX_WIDTH line store entries,
// then two bound divisions; no pixel is taken meanwhile
// a result waits in the output register; a stall there holds only the next emitting pixel
module box_filter_downscaler_top
   import bfd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_in_ch0,
   input  logic [PIX_W-1:0]  req_in_ch1,
   input  logic [PIX_W-1:0]  req_in_ch2,
   input  logic [PIX_W-1:0]  req_in_ch3,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_out_ch0,
   output logic [PIX_W-1:0]  rsp_out_ch1,
   output logic [PIX_W-1:0]  rsp_out_ch2,
   output logic [PIX_W-1:0]  rsp_out_ch3,
   output logic              rsp_row_last,
   output logic              rsp_frame_last,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // configuration
   logic [SW_W-1:0] src_width_ff, dst_width_ff;
   logic [SH_W-1:0] src_height_ff, dst_height_ff;
   logic            four_ch_ff;

   // effective sizes
   logic [SW_W-1:0] sw, dw, dwt;
   logic [SH_W-1:0] sh, dh, dht;

   state_type state_ff, state_in;

   logic [AW-1:0]   clr_ff, clr_in;
   logic [SW_W-1:0] src_col_ff, src_col_in, out_col_ff, out_col_in;
   logic [SW_W-1:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [SW_W-1:0] first_col_ff, first_col_in;
   logic [SH_W-1:0] src_row_ff, src_row_in, out_row_ff, out_row_in;
   logic [SH_W-1:0] row_start_ff, row_start_in, row_end_ff, row_end_in;
   logic [SH_W-1:0] first_row_ff, first_row_in;
   logic [PIX_W-1:0] pix_ff [NCH];
   logic            emit_ff, rl_ff, fl_ff;

   logic [SW_W:0]   sc1;
   logic [SH_W:0]   sr1;
   logic            emit, row_wrap, need_col, need_row, rl, fl;
   logic [SW_W+SW_W:0] col_mul;
   logic [SH_W+SH_W:0] row_mul;
   logic [SW_W-1:0] box_w;
   logic [SH_W-1:0] box_h;
   logic [AREA_W-1:0] area_mul, area;

   logic              bnd_start, bnd_busy;
   logic [BND_NW-1:0] bnd_numer, bnd_quot;
   logic [BND_DW-1:0] bnd_denom;

   lane_ctl_type      lane_ctl;
   logic [AW-1:0]     lane_addr;
   logic [NCH-1:0]    lane_busy;
   logic [NCH-1:0]    lane_en;
   logic [PIX_W-1:0]  lane_avg [NCH];

   logic merge_load, can_load, commit, accept, clr_last, div_done;

   // size clamping
   always_comb begin
      if (src_width_ff == '0) begin
         sw = SW_W'(1);
      end else if (32'(src_width_ff) > MAX_WIDTH) begin
         sw = SW_W'(MAX_WIDTH);
      end else begin
         sw = src_width_ff;
      end
      sh  = (src_height_ff == '0) ? SH_W'(1) : src_height_ff;
      dwt = (dst_width_ff == '0) ? SW_W'(1) : dst_width_ff;
      dw  = (dwt > sw) ? sw : dwt;
      dht = (dst_height_ff == '0) ? SH_W'(1) : dst_height_ff;
      dh  = (dht > sh) ? sh : dht;
   end

   // box position tests and products; the next box ends at bound of index plus two
   always_comb begin
      sc1      = {1'b0, src_col_ff} + 1'b1;
      sr1      = {1'b0, src_row_ff} + 1'b1;
      emit     = (sc1 >= {1'b0, col_end_ff}) && (sr1 >= {1'b0, row_end_ff});
      row_wrap = sc1 >= {1'b0, sw};
      need_col = !row_wrap && (sc1 >= {1'b0, col_end_ff});
      need_row = row_wrap && (sr1 >= {1'b0, row_end_ff}) && (sr1 < {1'b0, sh});
      rl       = ({1'b0, out_col_ff} + 1'b1) == {1'b0, dw};
      fl       = rl && (({1'b0, out_row_ff} + 1'b1) == {1'b0, dh});
      col_mul  = ({1'b0, out_col_ff} + 2'd2) * sw;
      row_mul  = ({1'b0, out_row_ff} + 2'd2) * sh;
      box_w    = col_end_ff - col_start_ff;
      box_h    = row_end_ff - row_start_ff;
      area_mul = AREA_W'(box_w) * AREA_W'(box_h);
      area     = (area_mul == '0) ? AREA_W'(1) : area_mul;
   end

   assign accept   = req_valid && !req_stall;
   assign clr_last = clr_ff == AW'(MAX_WIDTH - 1);
   assign div_done = !bnd_busy && !(|lane_busy);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (clr_last) state_in = ST_INIT_COL;
         ST_INIT_COL: if (!bnd_busy) state_in = ST_INIT_ROW;
         ST_INIT_ROW: if (!bnd_busy) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_READ;
         ST_READ:     state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = emit_ff ? ST_PUSH : ST_IDLE;
            end
         end
         ST_PUSH:     if (can_load) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
      if (csr_we) begin
         state_in = ST_CLEAR;
      end
   end

   // state outputs
   always_comb begin
      req_stall  = 1'b1;
      lane_ctl   = '0;
      lane_addr  = AW'(out_col_ff);
      bnd_start  = 1'b0;
      bnd_numer  = BND_NW'(sw);
      bnd_denom  = BND_DW'(dw);
      merge_load = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            lane_ctl.wr_en   = 1'b1;
            lane_ctl.wr_zero = 1'b1;
            lane_addr        = clr_ff;
            bnd_start        = clr_last;
         end
         ST_INIT_COL: begin
            bnd_start = !bnd_busy;
            bnd_numer = BND_NW'(sh);
            bnd_denom = BND_DW'(dh);
         end
         ST_INIT_ROW: begin
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            lane_ctl.wr_en     = 1'b1;
            lane_ctl.wr_zero   = emit;
            lane_ctl.div_start = emit;
            bnd_start          = need_col || need_row;
            if (need_row) begin
               bnd_numer = row_mul[BND_NW-1:0];
               bnd_denom = BND_DW'(dh);
            end else begin
               bnd_numer = BND_NW'(col_mul);
               bnd_denom = BND_DW'(dw);
            end
         end
         ST_DIV: begin
            commit = div_done && !emit_ff;
         end
         ST_PUSH: begin
            merge_load = can_load;
            commit     = can_load;
         end
         default: begin
         end
      endcase
   end

   // counters and box edges
   always_comb begin
      clr_in       = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      src_col_in   = src_col_ff;
      out_col_in   = out_col_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      first_col_in = first_col_ff;
      src_row_in   = src_row_ff;
      out_row_in   = out_row_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      first_row_in = first_row_ff;
      if (commit) begin
         if (row_wrap) begin
            src_col_in   = '0;
            out_col_in   = '0;
            col_start_in = '0;
            col_end_in   = first_col_ff;
            src_row_in   = sr1[SH_W-1:0];
            if (sr1 >= {1'b0, row_end_ff}) begin
               out_row_in   = out_row_ff + 1'b1;
               row_start_in = row_end_ff;
               row_end_in   = bnd_quot[SH_W-1:0];
            end
            if (sr1 >= {1'b0, sh}) begin
               src_row_in   = '0;
               out_row_in   = '0;
               row_start_in = '0;
               row_end_in   = first_row_ff;
            end
         end else begin
            src_col_in = sc1[SW_W-1:0];
            if (need_col) begin
               out_col_in   = out_col_ff + 1'b1;
               col_start_in = col_end_ff;
               col_end_in   = bnd_quot[SW_W-1:0];
            end
         end
      end
      if (state_ff == ST_INIT_COL && !bnd_busy) begin
         first_col_in = bnd_quot[SW_W-1:0];
      end
      if (state_ff == ST_INIT_ROW && !bnd_busy) begin
         first_row_in = bnd_quot[SH_W-1:0];
         col_end_in   = first_col_ff;
         row_end_in   = bnd_quot[SH_W-1:0];
      end
      if (csr_we) begin
         clr_in       = '0;
         src_col_in   = '0;
         out_col_in   = '0;
         col_start_in = '0;
         src_row_in   = '0;
         out_row_in   = '0;
         row_start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff[0] <= req_in_ch0;
         pix_ff[1] <= req_in_ch1;
         pix_ff[2] <= req_in_ch2;
         pix_ff[3] <= req_in_ch3;
      end
      if (state_ff == ST_READ) begin
         emit_ff <= emit;
         rl_ff   <= rl;
         fl_ff   <= fl;
      end
      col_end_ff   <= col_end_in;
      first_col_ff <= first_col_in;
      row_end_ff   <= row_end_in;
      first_row_ff <= first_row_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         src_col_ff    <= '0;
         out_col_ff    <= '0;
         col_start_ff  <= '0;
         src_row_ff    <= '0;
         out_row_ff    <= '0;
         row_start_ff  <= '0;
         src_width_ff  <= SW_W'(1);
         src_height_ff <= SH_W'(1);
         dst_width_ff  <= SW_W'(1);
         dst_height_ff <= SH_W'(1);
         four_ch_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         src_col_ff   <= src_col_in;
         out_col_ff   <= out_col_in;
         col_start_ff <= col_start_in;
         src_row_ff   <= src_row_in;
         out_row_ff   <= out_row_in;
         row_start_ff <= row_start_in;
         if (csr_we) begin
            case (csr_index)
               REG_SRC_WIDTH:     src_width_ff  <= csr_wdata[SW_W-1:0];
               REG_SRC_HEIGHT:    src_height_ff <= csr_wdata[SH_W-1:0];
               REG_DST_WIDTH:     dst_width_ff  <= csr_wdata[SW_W-1:0];
               REG_DST_HEIGHT:    dst_height_ff <= csr_wdata[SH_W-1:0];
               REG_FOUR_CHANNELS: four_ch_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // box bound divider
   bfd_div #(
      .NW(BND_NW),
      .DW(BND_DW)
   ) u_bnd_div (
      .clock(clock),
      .reset(reset),
      .start(bnd_start),
      .numer(bnd_numer),
      .denom(bnd_denom),
      .busy (bnd_busy),
      .quot (bnd_quot)
   );

   // one lane per channel
   assign lane_en = {four_ch_ff, 3'b111};

   for (genvar i = 0; i < NCH; i++) begin : g_lane
      bfd_lane #(
         .MAX_WIDTH(MAX_WIDTH),
         .AW       (AW)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .ctl  (lane_ctl),
         .addr (lane_addr),
         .pix  (pix_ff[i]),
         .en   (lane_en[i]),
         .area (area),
         .busy (lane_busy[i]),
         .avg  (lane_avg[i])
      );
   end

   // output word
   bfd_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (merge_load),
      .four_ch       (four_ch_ff),
      .lane_avg      (lane_avg),
      .row_last      (rl_ff),
      .frame_last    (fl_ff),
      .rsp_stall     (rsp_stall),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_out_ch0   (rsp_out_ch0),
      .rsp_out_ch1   (rsp_out_ch1),
      .rsp_out_ch2   (rsp_out_ch2),
      .rsp_out_ch3   (rsp_out_ch3),
      .rsp_row_last  (rsp_row_last),
      .rsp_frame_last(rsp_frame_last)
   );

endmodule

>>> design/bfd_div.sv
module bfd_div
   import bfd_pkg::*;
#(
   parameter int NW = 32,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          busy,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {r_ff[DW-1:0], q_ff[NW-1]};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = numer;
         r_in    = '0;
         d_in    = denom;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

>>> design/bfd_lane.sv
module bfd_lane
   import bfd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  lane_ctl_type      ctl,
   input  logic [AW-1:0]     addr,
   input  logic [PIX_W-1:0]  pix,
   input  logic              en,
   input  logic [AREA_W-1:0] area,
   output logic              busy,
   output logic [PIX_W-1:0]  avg
);

   logic [SUM_W-1:0] mem_ff [MAX_WIDTH];
   logic [SUM_W-1:0] rd_q_ff;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] quot;

   // column sum plus this channel byte, wrapping
   always_comb begin
      sum = rd_q_ff + (en ? SUM_W'(pix) : '0);
   end

   // line store: registered read, one write port
   always_ff @(posedge clock) begin
      rd_q_ff <= mem_ff[addr];
      if (ctl.wr_en) begin
         mem_ff[addr] <= ctl.wr_zero ? '0 : sum;
      end
   end

   // box average
   bfd_div #(
      .NW(SUM_W),
      .DW(AREA_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(ctl.div_start),
      .numer(sum),
      .denom(area),
      .busy (busy),
      .quot (quot)
   );

   assign avg = quot[PIX_W-1:0];

endmodule

>>> design/bfd_merge.sv
module bfd_merge
   import bfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             four_ch,
   input  logic [PIX_W-1:0] lane_avg [NCH],
   input  logic             row_last,
   input  logic             frame_last,
   input  logic             rsp_stall,
   output logic             can_load,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_out_ch0,
   output logic [PIX_W-1:0] rsp_out_ch1,
   output logic [PIX_W-1:0] rsp_out_ch2,
   output logic [PIX_W-1:0] rsp_out_ch3,
   output logic             rsp_row_last,
   output logic             rsp_frame_last
);

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] ch_ff [NCH];
   logic             rl_ff, fl_ff;

   // output register frees when empty or being taken
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // gather lane results into one word
   always_ff @(posedge clock) begin
      if (load) begin
         ch_ff[0] <= lane_avg[0];
         ch_ff[1] <= lane_avg[1];
         ch_ff[2] <= lane_avg[2];
         ch_ff[3] <= four_ch ? lane_avg[3] : '0;
         rl_ff    <= row_last;
         fl_ff    <= frame_last;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_ch0    = ch_ff[0];
   assign rsp_out_ch1    = ch_ff[1];
   assign rsp_out_ch2    = ch_ff[2];
   assign rsp_out_ch3    = ch_ff[3];
   assign rsp_row_last   = rl_ff;
   assign rsp_frame_last = fl_ff;

endmodule

>>> design/bfd_checker.sv
module bfd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_row_last,
   input logic rsp_frame_last,
   input logic csr_we
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped under stall");

   // one pixel at a time: stall follows every accepted word
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("pixel taken while previous one in progress");

   // a register write restarts the frame and the clearing pass
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("pixel taken during clearing pass");

   // image end is always a row end
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_last || rsp_row_last))
      else $error("frame_last without row_last");

endmodule

bind box_filter_downscaler_top bfd_checker u_bfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_last  (rsp_row_last),
   .rsp_frame_last(rsp_frame_last),
   .csr_we        (csr_we)
);
